@@ src/mstp_pkg.sv @@
`default_nettype none
package mstp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int WEIGHT_BITS  = 16;

  // fixed field widths
  localparam int VC_W   = 7;
  localparam int NODE_W = 6;

  localparam logic [VC_W-1:0]   VC_RESET = 7'd64;
  localparam logic [NODE_W-1:0] SV_RESET = 6'd0;

  typedef enum logic {
    REG_VERTEX_COUNT = 1'b0,
    REG_START_VERTEX = 1'b1
  } reg_idx_t;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_LOAD   = 6'b000010,
    S_INS    = 6'b000100,
    S_RSTART = 6'b001000,
    S_VISIT  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

endpackage
`default_nettype wire

@@ src/mstp_if.sv @@
`default_nettype none
interface mstp_in_if #(parameter int W = mstp_pkg::WEIGHT_BITS);
  logic                        valid;
  logic                        ready;
  logic                        has_edge;
  logic [mstp_pkg::NODE_W-1:0] node_a;
  logic [mstp_pkg::NODE_W-1:0] node_b;
  logic signed [W-1:0]         edge_cost;
  logic                        last_edge;
  modport source (output valid, has_edge, node_a, node_b, edge_cost, last_edge, input ready);
  modport sink   (input valid, has_edge, node_a, node_b, edge_cost, last_edge, output ready);
endinterface

interface mstp_out_if #(parameter int W = mstp_pkg::WEIGHT_BITS);
  logic                        valid;
  logic                        ready;
  logic [mstp_pkg::NODE_W-1:0] from_vertex;
  logic [mstp_pkg::NODE_W-1:0] to_vertex;
  logic signed [W-1:0]         tree_edge_cost;
  logic                        edge_found;
  logic                        last_result;
  modport source (output valid, from_vertex, to_vertex, tree_edge_cost, edge_found,
                  last_result, input ready);
  modport sink   (input valid, from_vertex, to_vertex, tree_edge_cost, edge_found,
                  last_result, output ready);
endinterface
`default_nettype wire

@@ src/mstp_ram.sv @@
`default_nettype none
// simple dual-port RAM, registered read
module mstp_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 17
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [1<<ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/minimum_spanning_tree_prim_unit.sv @@
`default_nettype none
// Edge load: an in-range edge adds an insert step (S_INS) in which no new transaction is taken.
// Tree run: a start step, then per found edge a relaxation pass over the adjacency row through
//   the store and link RAM ports, plus the emit step; unreachable tail results are an emit step
//   each; a stalled result holds the run. vertex_count saturates at MAX_VERTICES. After each run
//   and after reset a clearing pass over (2**clog2(MAX_VERTICES))**2 store addresses (4096 by
//   default) wipes store, links and visited marks; reset (rst_n, sync, active low) starts it.
module minimum_spanning_tree_prim_unit #(
  parameter int MAX_VERTICES = mstp_pkg::MAX_VERTICES,
  parameter int WEIGHT_BITS  = mstp_pkg::WEIGHT_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  mstp_in_if.sink                        in_ch,
  mstp_out_if.source                     out_ch,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [mstp_pkg::VC_W-1:0] cfg_wdata
);
  localparam int VW   = $clog2(MAX_VERTICES);   // vertex index width
  localparam int NW   = VW + 1;                 // count width
  localparam int SA_W = 2 * VW;                 // store address: {lo, hi}
  localparam int SD_W = WEIGHT_BITS + 1;        // {valid, weight}
  localparam int LD_W = WEIGHT_BITS + 2 + VW;   // {visited, valid, weight, parent}
  localparam int NOW  = mstp_pkg::NODE_W;

  // link entry of a vertex already in the tree
  localparam logic [LD_W-1:0] LK_SEEN = {1'b1, {(LD_W-1){1'b0}}};

  mstp_pkg::state_t state_r, state_nxt;

  logic [mstp_pkg::VC_W-1:0] vc_r;
  logic [NOW-1:0]            sv_r;

  // effective vertex count
  logic [31:0]   vc32, eff32;
  logic          sv_ok;
  logic [VW-1:0] sv_idx;
  always_comb begin
    vc32   = 32'(vc_r);
    eff32  = (vc32 > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : vc32;
    sv_ok  = 32'(sv_r) < eff32;
    sv_idx = VW'(sv_r);
  end

  // ---------------------------------------------------------------- registers
  logic [SA_W-1:0]               clr_cnt_r;
  logic                          ins_last_r;
  logic signed [WEIGHT_BITS-1:0] ins_w_r;
  logic [SA_W-1:0]               ins_addr_r;
  logic [NW-1:0]                 k_r;
  logic [VW-1:0]                 u_r;
  logic [NW-1:0]                 x_cnt_r;
  logic                          p_v_r;
  logic [VW-1:0]                 p_x_r;
  logic                          bf_r;
  logic signed [WEIGHT_BITS-1:0] bw_r;
  logic [VW-1:0]                 bx_r, bp_r;
  logic                          ov_r;
  logic [NOW-1:0]                o_from_r, o_to_r;
  logic signed [WEIGHT_BITS-1:0] o_w_r;
  logic                          o_found_r, o_last_r;

  // ---------------------------------------------------------------- memories
  logic            st_we;
  logic [SA_W-1:0] st_waddr, st_raddr;
  logic [SD_W-1:0] st_wdata, st_rdata;
  logic            lk_we;
  logic [VW-1:0]   lk_waddr, lk_raddr;
  logic [LD_W-1:0] lk_wdata, lk_rdata;

  mstp_ram #(.ADDR_W(SA_W), .DATA_W(SD_W)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  mstp_ram #(.ADDR_W(VW), .DATA_W(LD_W)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );

  // ---------------------------------------------------------------- input side
  logic          in_acc, in_range;
  logic [31:0]   na32, nb32;
  logic [VW-1:0] na, nb, in_lo, in_hi;
  always_comb begin
    in_ch.ready = (state_r == mstp_pkg::S_LOAD);
    in_acc      = in_ch.valid && in_ch.ready;
    na32        = 32'(in_ch.node_a);
    nb32        = 32'(in_ch.node_b);
    in_range    = (na32 < eff32) && (nb32 < eff32);
    na          = na32[VW-1:0];
    nb          = nb32[VW-1:0];
    in_lo       = (na < nb) ? na : nb;
    in_hi       = (na < nb) ? nb : na;
  end

  // insert: keep the lighter of parallel edges
  logic                          st_v;
  logic signed [WEIGHT_BITS-1:0] st_w;
  logic                          ins_upd;
  always_comb begin
    st_v    = st_rdata[SD_W-1];
    st_w    = st_rdata[WEIGHT_BITS-1:0];
    ins_upd = !st_v || (ins_w_r < st_w);
  end

  // ---------------------------------------------------------------- relaxation
  logic [VW-1:0] x_idx, row_lo, row_hi;
  logic          issue, pass_done;
  logic                          lk_v, vis, upd, cand, better;
  logic signed [WEIGHT_BITS-1:0] lk_w, nw;
  logic [VW-1:0]                 lk_p;
  logic                          nv;
  logic [VW-1:0]                 np;
  always_comb begin
    x_idx  = x_cnt_r[VW-1:0];
    row_lo = (u_r < x_idx) ? u_r : x_idx;
    row_hi = (u_r < x_idx) ? x_idx : u_r;
    issue  = (state_r == mstp_pkg::S_VISIT) && (32'(x_cnt_r) < eff32);
    pass_done = p_v_r && (32'(p_x_r) + 32'd1 == eff32);

    vis  = lk_rdata[LD_W-1];
    lk_v = lk_rdata[LD_W-2];
    lk_w = lk_rdata[VW +: WEIGHT_BITS];
    lk_p = lk_rdata[VW-1:0];
    // lighter weight wins; equal weight goes to the smaller parent
    upd  = !vis && st_v && (!lk_v || (st_w < lk_w) || ((st_w == lk_w) && (u_r < lk_p)));
    nv   = upd ? 1'b1 : lk_v;
    nw   = upd ? st_w : lk_w;
    np   = upd ? u_r  : lk_p;
    cand = !vis && nv;
    // ascending scan: ties on weight keep the smaller vertex
    better = cand && (!bf_r || (nw < bw_r));
  end

  // ---------------------------------------------------------------- result side
  logic        out_free, is_last, emit_fire;
  logic [31:0] bp32, bx32;
  always_comb begin
    out_free  = !ov_r || out_ch.ready;
    is_last   = (32'(k_r) + 32'd2 == eff32);
    emit_fire = (state_r == mstp_pkg::S_EMIT) && out_free;
    bp32      = 32'(bp_r);
    bx32      = 32'(bx_r);
    out_ch.valid          = ov_r;
    out_ch.from_vertex    = o_from_r;
    out_ch.to_vertex      = o_to_r;
    out_ch.tree_edge_cost = o_w_r;
    out_ch.edge_found     = o_found_r;
    out_ch.last_result    = o_last_r;
  end

  // memory ports
  always_comb begin
    st_we    = 1'b0;
    st_waddr = ins_addr_r;
    st_wdata = {1'b1, ins_w_r};
    st_raddr = {row_lo, row_hi};
    lk_we    = 1'b0;
    lk_waddr = p_x_r;
    lk_wdata = {1'b0, nv, nw, np};
    lk_raddr = x_idx;
    if (state_r == mstp_pkg::S_LOAD) begin
      st_raddr = {in_lo, in_hi};
    end
    if (state_r == mstp_pkg::S_INS) begin
      st_we = ins_upd;
    end
    if (state_r == mstp_pkg::S_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_cnt_r;
      st_wdata = '0;
      lk_we    = 1'b1;
      lk_waddr = clr_cnt_r[VW-1:0];
      lk_wdata = '0;
    end
    // visited marks live in the link entries
    if (state_r == mstp_pkg::S_RSTART && sv_ok) begin
      lk_we    = 1'b1;
      lk_waddr = sv_idx;
      lk_wdata = LK_SEEN;
    end
    if (emit_fire && !is_last && bf_r) begin
      lk_we    = 1'b1;
      lk_waddr = bx_r;
      lk_wdata = LK_SEEN;
    end
    if (p_v_r && upd) begin
      lk_we = 1'b1;
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mstp_pkg::S_CLEAR: begin
        if (&clr_cnt_r) state_nxt = mstp_pkg::S_LOAD;
      end
      mstp_pkg::S_LOAD: begin
        if (in_acc) begin
          if (in_ch.has_edge && in_range) state_nxt = mstp_pkg::S_INS;
          else if (in_ch.last_edge)       state_nxt = mstp_pkg::S_RSTART;
        end
      end
      mstp_pkg::S_INS: begin
        state_nxt = ins_last_r ? mstp_pkg::S_RSTART : mstp_pkg::S_LOAD;
      end
      mstp_pkg::S_RSTART: begin
        if (eff32 < 32'd2)                  state_nxt = mstp_pkg::S_CLEAR;
        else if (sv_ok)                     state_nxt = mstp_pkg::S_VISIT;
        else                                state_nxt = mstp_pkg::S_EMIT;
      end
      mstp_pkg::S_VISIT: begin
        if (pass_done) state_nxt = mstp_pkg::S_EMIT;
      end
      mstp_pkg::S_EMIT: begin
        if (out_free) begin
          if (is_last)   state_nxt = mstp_pkg::S_CLEAR;
          else if (bf_r) state_nxt = mstp_pkg::S_VISIT;
        end
      end
      default: state_nxt = mstp_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mstp_pkg::S_CLEAR;
      vc_r      <= mstp_pkg::VC_RESET;
      sv_r      <= mstp_pkg::SV_RESET;
      clr_cnt_r <= '0;
      p_v_r     <= 1'b0;
      ov_r      <= 1'b0;
      bf_r      <= 1'b0;
      k_r       <= '0;
      x_cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          mstp_pkg::REG_VERTEX_COUNT: vc_r <= cfg_wdata;
          mstp_pkg::REG_START_VERTEX: sv_r <= cfg_wdata[NOW-1:0];
          default: ;
        endcase
      end

      if (state_r == mstp_pkg::S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;

      if (in_acc) begin
        ins_last_r <= in_ch.last_edge;
        ins_w_r    <= in_ch.edge_cost;
        ins_addr_r <= {in_lo, in_hi};
      end

      // relaxation pipeline
      p_v_r <= issue;
      p_x_r <= x_idx;
      if (issue) x_cnt_r <= x_cnt_r + 1'b1;
      if (p_v_r && better) begin
        bf_r <= 1'b1;
        bw_r <= nw;
        bx_r <= p_x_r;
        bp_r <= np;
      end

      if (state_r == mstp_pkg::S_RSTART) begin
        k_r     <= '0;
        bf_r    <= 1'b0;
        x_cnt_r <= '0;
        u_r     <= sv_ok ? sv_idx : '0;
        if (eff32 < 32'd2) clr_cnt_r <= '0;
      end

      ov_r <= emit_fire || (ov_r && !out_ch.ready);

      if (emit_fire) begin
        o_found_r <= bf_r;
        o_from_r  <= bf_r ? bp32[NOW-1:0] : '0;
        o_to_r    <= bf_r ? bx32[NOW-1:0] : '0;
        o_w_r     <= bf_r ? bw_r : '0;
        o_last_r  <= is_last;
        k_r       <= k_r + 1'b1;
        if (is_last) begin
          clr_cnt_r <= '0;
        end else if (bf_r) begin
          // next pass relaxes from the vertex just added
          u_r     <= bx_r;
          x_cnt_r <= '0;
          bf_r    <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire
